// ----- sv/lrgp_pkg.sv -----
// types, constants and register indexes of the linear resampler with gain and peak
`default_nettype none

package lrgp_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int BLOCK_LEN = 256;
    localparam int RATIO_W   = 20;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int CNT_W     = $clog2(BLOCK_LEN + 1);

    localparam logic [RATIO_W-1:0] RATIO_MIN = RATIO_W'(8192);
    localparam logic [RATIO_W-1:0] RATIO_MAX = RATIO_W'(524288);
    localparam logic [RATIO_W-1:0] PHASE_ONE = RATIO_W'(65536);
    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(65536);
    localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       end_of_sound;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       block_last;
        logic signed [SAMPLE_W-1:0] block_peak;
        logic                       sound_done;
    } t_out;

endpackage

`default_nettype wire

// ----- sv/linear_resampler_gain_peak_core.sv -----
// top level: linear interpolation resampler with volume gain and block peak
`default_nettype none

// Mono samples enter one per transfer; each gives zero to eight interpolated
// outputs (one more on end of sound), each scaled by the volume gain and
// saturated, with the largest-magnitude output of every block of BLOCK_LEN
// outputs (fewer at end of sound) reported on that block's last output. One
// 17x17 multiplier is shared by interpolation and gain under a small
// sequencer: the first sample of a sound is only held, any other input passes
// S_LOOP, then S_INTERP, S_GAIN and S_EMIT per output, and the end-of-sound
// output passes S_FINAL, S_GAIN and S_EMIT; S_EMIT waits while the output
// side stalls. The input is not taken while an item is in work; the output
// register lets the next output be computed while the previous one waits.
module linear_resampler_gain_peak_core (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lrgp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [lrgp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  lrgp_pkg::t_in                 i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output lrgp_pkg::t_out                      o_out_data
);
    import lrgp_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int INT_W  = PROD_W - 16;
    localparam int GV_W   = PROD_W - 15;

    localparam logic signed [GV_W-1:0] SMAX = GV_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [GV_W-1:0] SMIN = -SMAX - GV_W'(1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOP   = 6'b000010,
        S_INTERP = 6'b000100,
        S_GAIN   = 6'b001000,
        S_EMIT   = 6'b010000,
        S_FINAL  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [RATIO_W-1:0]         r_ratio, n_ratio;
    logic [GAIN_W-1:0]          r_gain, n_gain;
    logic signed [SAMPLE_W-1:0] r_prev, n_prev;
    logic signed [SAMPLE_W-1:0] r_cur, n_cur;
    logic                       r_eos, n_eos;
    logic [RATIO_W-1:0]         r_phase, n_phase;
    logic                       r_have_prev, n_have_prev;
    logic [CNT_W-1:0]           r_count, n_count;
    logic signed [SAMPLE_W-1:0] r_peak, n_peak;
    logic signed [DIFF_W-1:0]   r_samp, n_samp;
    logic                       r_done, n_done;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic                       r_out_valid, n_out_valid;
    t_out                       r_out, n_out;

    logic [RATIO_W-1:0]         ratio_clamped;
    logic signed [DIFF_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   int_rnd;
    logic signed [INT_W-1:0]    int_sum;
    logic signed [PROD_W-1:0]   g_rnd;
    logic signed [GV_W-1:0]     g_val;
    logic signed [SAMPLE_W-1:0] g_sat;
    logic signed [SAMPLE_W-1:0] peak_next;
    logic [CNT_W-1:0]           count_inc;
    logic                       last;

    function automatic logic [SAMPLE_W:0] mag(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W:0] w;
        w = {v[SAMPLE_W-1], v};
        return v[SAMPLE_W-1] ? $unsigned(-w) : $unsigned(w);
    endfunction

    always_comb begin
        if (r_ratio < RATIO_MIN) begin
            ratio_clamped = RATIO_MIN;
        end else if (r_ratio > RATIO_MAX) begin
            ratio_clamped = RATIO_MAX;
        end else begin
            ratio_clamped = r_ratio;
        end
    end

    // shared multiplier: source difference times phase fraction, or sample times gain
    always_comb begin
        if (r_state == S_GAIN) begin
            mul_a = r_samp;
            mul_b = $signed({1'b0, r_gain});
        end else begin
            mul_a = $signed({r_cur[SAMPLE_W-1], r_cur}) - $signed({r_prev[SAMPLE_W-1], r_prev});
            mul_b = $signed({1'b0, r_phase[15:0]});
        end
        mul_p = mul_a * mul_b;
    end

    // round half up, then back into sample range
    assign int_rnd = r_prod + PROD_W'(32768);
    assign int_sum = $signed(int_rnd[PROD_W-1:16]) + INT_W'(r_prev);

    assign g_rnd = r_prod + PROD_W'(16384);
    assign g_val = $signed(g_rnd[PROD_W-1:15]);

    always_comb begin
        if (g_val > SMAX) begin
            g_sat = SAMPLE_W'(SMAX);
        end else if (g_val < SMIN) begin
            g_sat = SAMPLE_W'(SMIN);
        end else begin
            g_sat = g_val[SAMPLE_W-1:0];
        end
    end

    assign peak_next = (mag(g_sat) > mag(r_peak)) ? g_sat : r_peak;
    assign count_inc = r_count + CNT_W'(1);
    assign last      = r_done || (count_inc >= CNT_W'(BLOCK_LEN));

    always_comb begin
        n_state     = r_state;
        n_ratio     = r_ratio;
        n_gain      = r_gain;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_eos       = r_eos;
        n_phase     = r_phase;
        n_have_prev = r_have_prev;
        n_count     = r_count;
        n_peak      = r_peak;
        n_samp      = r_samp;
        n_done      = r_done;
        n_prod      = r_prod;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RATIO: n_ratio = i_cfg_data[RATIO_W-1:0];
                CFG_GAIN:  n_gain  = i_cfg_data[GAIN_W-1:0];
                default:   n_gain  = r_gain;
            endcase
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur = i_in_data.in_sample;
                    n_eos = i_in_data.end_of_sound;
                    if (r_have_prev) begin
                        n_state = S_LOOP;
                    end else begin
                        // first sample of a sound is only held
                        n_have_prev = 1'b1;
                        n_phase     = '0;
                        n_prev      = i_in_data.in_sample;
                        n_state     = i_in_data.end_of_sound ? S_FINAL : S_IDLE;
                    end
                end
            end
            S_LOOP: begin
                if (r_phase < PHASE_ONE) begin
                    n_prod  = mul_p;
                    n_state = S_INTERP;
                end else begin
                    n_phase = r_phase - PHASE_ONE;
                    n_prev  = r_cur;
                    n_state = r_eos ? S_FINAL : S_IDLE;
                end
            end
            S_INTERP: begin
                n_samp  = int_sum[DIFF_W-1:0];
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_prod  = mul_p;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.out_sample   = g_sat;
                    n_out.block_last   = last;
                    n_out.block_peak   = last ? peak_next : '0;
                    n_out.sound_done   = r_done;
                    if (last) begin
                        n_count = '0;
                        n_peak  = '0;
                    end else begin
                        n_count = count_inc;
                        n_peak  = peak_next;
                    end
                    if (r_done) begin
                        n_prev      = '0;
                        n_phase     = '0;
                        n_have_prev = 1'b0;
                        n_count     = '0;
                        n_peak      = '0;
                        n_done      = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_phase = r_phase + ratio_clamped;
                        n_state = S_LOOP;
                    end
                end
            end
            S_FINAL: begin
                n_samp  = {r_cur[SAMPLE_W-1], r_cur};
                n_done  = 1'b1;
                n_state = S_GAIN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ratio     <= RATIO_RST;
            r_gain      <= GAIN_RST;
            r_prev      <= '0;
            r_phase     <= '0;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_peak      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ratio     <= n_ratio;
            r_gain      <= n_gain;
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_have_prev <= n_have_prev;
            r_count     <= n_count;
            r_peak      <= n_peak;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_eos  <= n_eos;
        r_samp <= n_samp;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
